// ----- rtl/core/aht_pkg.sv -----
// shared types and constants for the averaging hysteresis thermostat
`default_nettype none

package aht_pkg;

  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HYST   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd2;

  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_HEAT = 2'd1;
  localparam logic [1:0] MODE_AUTO = 2'd2;

  localparam logic [8:0] TARGET_RST = 9'd100;
  localparam logic [6:0] HYST_RST   = 7'd10;

  localparam int TEMP_W = 12;
  localparam int ERR_W  = 16;

  typedef struct packed {
    logic signed [TEMP_W-1:0] sample_temp;
    logic                     sample_ok;
  } in_t;

  typedef struct packed {
    logic                     heater_on;
    logic                     heater_changed;
    logic                     window_end;
    logic                     avg_valid;
    logic signed [TEMP_W-1:0] avg_temp;
    logic                     report_temp;
    logic [ERR_W-1:0]         error_total;
  } out_t;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_need;
    logic div_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/averaging_hysteresis_thermostat_core.sv -----
// top level of the averaging hysteresis thermostat
`default_nettype none

// One request per sensor sample. A request that does not close a good window
// goes through intake and commit; one that closes a good window also runs the
// window average through a serial divider giving one quotient bit per cycle
// over a 16-bit sum. A result waits in an output register; the next request
// is taken while it waits, and commit holds while the register is still full
// and out_stall is high.
module averaging_hysteresis_thermostat_core #(
  parameter int WINDOW_SAMPLES = 5
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire aht_pkg::in_t                   in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output aht_pkg::out_t                       out_data,
  input  wire logic                           cfg_we,
  input  wire logic [aht_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [aht_pkg::CFG_DATA_W-1:0] cfg_data
);

  aht_pkg::ctrl_cmd_t  cmd;
  aht_pkg::dp_status_t status;

  aht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  aht_dpath #(
    .WINDOW_SAMPLES (WINDOW_SAMPLES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- rtl/core/aht_ctrl.sv -----
// sequencer for request intake, average division and result commit
`default_nettype none

module aht_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire aht_pkg::dp_status_t status,
  output aht_pkg::ctrl_cmd_t       cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd.accept   = 1'b0;
    cmd.div_step = 1'b0;
    cmd.commit   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = status.div_need ? ST_DIV : ST_FIN;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && status.div_last) |=> (state_r == ST_FIN))
    else $error("divider exit missed");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.accept, cmd.div_step, cmd.commit}))
    else $error("overlapping commands");

  a_commit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> !in_stall)
    else $error("not idle after commit");

endmodule

`default_nettype wire

// ----- rtl/core/aht_dpath.sv -----
// window accumulation, serial divider, hysteresis decision and result register
`default_nettype none

module aht_dpath #(
  parameter int WINDOW_SAMPLES = 5
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire aht_pkg::in_t                      in_data,
  input  wire logic                              cfg_we,
  input  wire logic [aht_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [aht_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire aht_pkg::ctrl_cmd_t                cmd,
  output aht_pkg::dp_status_t                    status,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output aht_pkg::out_t                          out_data
);

  localparam int CNT_W = 3;
  localparam int SUM_W = 16;
  localparam int STEP_W = $clog2(SUM_W);
  localparam int TW = aht_pkg::TEMP_W;
  localparam int EW = aht_pkg::ERR_W;

  // configuration
  logic [8:0] cfg_target_r;
  logic [6:0] cfg_hyst_r;
  logic [1:0] cfg_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_target_r <= aht_pkg::TARGET_RST;
      cfg_hyst_r   <= aht_pkg::HYST_RST;
      cfg_mode_r   <= aht_pkg::MODE_AUTO;
    end else if (cfg_we) begin
      unique case (cfg_index)
        aht_pkg::CFG_TARGET: cfg_target_r <= cfg_data[8:0];
        aht_pkg::CFG_HYST:   cfg_hyst_r   <= cfg_data[6:0];
        aht_pkg::CFG_MODE:   cfg_mode_r   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // good-window table, indexed by valid count
  logic [(1<<CNT_W)-1:0] good_tab;
  for (genvar g = 0; g < (1 << CNT_W); g++) begin : g_good
    assign good_tab[g] = (((100 * g) / WINDOW_SAMPLES) > 10) && (g != 0);
  end

  // accumulation state
  logic [CNT_W-1:0]        idx_r, idx_nxt;
  logic [CNT_W-1:0]        vcnt_r, vcnt_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [EW-1:0]           err_r, err_nxt;
  logic                    heater_r, heater_nxt;
  logic signed [TW-1:0]    avg_r, avg_nxt;
  logic signed [TW-1:0]    last_r, last_nxt;
  logic                    wend_r;
  logic                    good_r;

  logic [CNT_W-1:0]        idx_acc;
  logic [CNT_W-1:0]        vcnt_acc;
  logic signed [SUM_W-1:0] sum_acc;
  logic                    wend_acc;
  logic                    good_acc;

  always_comb begin
    idx_acc  = idx_r + 1'b1;
    vcnt_acc = in_data.sample_ok ? vcnt_r + 1'b1 : vcnt_r;
    sum_acc  = in_data.sample_ok
             ? sum_r + {{(SUM_W-TW){in_data.sample_temp[TW-1]}}, in_data.sample_temp}
             : sum_r;
    wend_acc = (idx_acc >= CNT_W'(WINDOW_SAMPLES));
    good_acc = wend_acc && good_tab[vcnt_acc];
    err_nxt  = err_r;
    if (!in_data.sample_ok && (err_r != {EW{1'b1}})) begin
      err_nxt = err_r + 1'b1;
    end
    idx_nxt  = wend_acc ? '0 : idx_acc;
    vcnt_nxt = wend_acc ? '0 : vcnt_acc;
    sum_nxt  = wend_acc ? '0 : sum_acc;
  end

  assign status.div_need = good_acc;

  // serial restoring divider on the magnitude, one quotient bit a cycle
  logic [SUM_W-1:0]  dnum_r, dnum_nxt;
  logic [CNT_W-1:0]  drem_r, drem_nxt;
  logic [CNT_W-1:0]  dden_r;
  logic              dneg_r;
  logic [STEP_W-1:0] dstep_r;
  logic [CNT_W:0]    dtrial;
  logic              dbit;

  always_comb begin
    dtrial   = {drem_r, dnum_r[SUM_W-1]};
    dbit     = (dtrial >= {1'b0, dden_r});
    drem_nxt = dbit ? CNT_W'(dtrial - {1'b0, dden_r}) : dtrial[CNT_W-1:0];
    dnum_nxt = {dnum_r[SUM_W-2:0], dbit};
  end

  assign status.div_last = (dstep_r == STEP_W'(SUM_W - 1));

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      dnum_r  <= sum_acc[SUM_W-1] ? SUM_W'(-sum_acc) : SUM_W'(sum_acc);
      dneg_r  <= sum_acc[SUM_W-1];
      dden_r  <= vcnt_acc;
      drem_r  <= '0;
      dstep_r <= '0;
    end else if (cmd.div_step) begin
      dnum_r  <= dnum_nxt;
      drem_r  <= drem_nxt;
      dstep_r <= dstep_r + 1'b1;
    end
  end

  // decision on commit
  logic signed [SUM_W-1:0] quot;
  logic signed [TW:0]      delta;
  logic [TW:0]             delta_abs;
  logic                    report;
  logic signed [10:0]      lo_t, hi_t;
  logic signed [16:0]      avg_x10, lo_x16, hi_x16;
  logic signed [16:0]      avg_ext;

  always_comb begin
    quot       = dneg_r ? SUM_W'(-dnum_r) : dnum_r;
    avg_nxt    = good_r ? quot[TW-1:0] : avg_r;
    delta      = {avg_nxt[TW-1], avg_nxt} - {last_r[TW-1], last_r};
    delta_abs  = delta[TW] ? (TW+1)'(-delta) : delta;
    // 10*|d| >= 16 holds for integers exactly when |d| >= 2
    report     = good_r && (delta_abs >= (TW+1)'(2));
    last_nxt   = report ? avg_nxt : last_r;
    lo_t       = $signed({2'b00, cfg_target_r}) - $signed({4'b0000, cfg_hyst_r});
    hi_t       = $signed({2'b00, cfg_target_r}) + $signed({4'b0000, cfg_hyst_r});
    avg_ext    = {{(17-TW){avg_nxt[TW-1]}}, avg_nxt};
    avg_x10    = (avg_ext <<< 3) + (avg_ext <<< 1);
    lo_x16     = {{2{lo_t[10]}}, lo_t, 4'b0000};
    hi_x16     = {{2{hi_t[10]}}, hi_t, 4'b0000};
    heater_nxt = heater_r;
    if (wend_r && (cfg_mode_r == aht_pkg::MODE_AUTO)) begin
      if (!good_r) begin
        heater_nxt = 1'b0;
      end else if (avg_x10 <= lo_x16) begin
        heater_nxt = 1'b1;
      end else if (avg_x10 >= hi_x16) begin
        heater_nxt = 1'b0;
      end
    end
    if (cfg_mode_r == aht_pkg::MODE_HEAT) begin
      heater_nxt = 1'b1;
    end else if (cfg_mode_r != aht_pkg::MODE_AUTO) begin
      heater_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      vcnt_r   <= '0;
      sum_r    <= '0;
      err_r    <= '0;
      heater_r <= 1'b0;
      avg_r    <= '0;
      last_r   <= '0;
      wend_r   <= 1'b0;
      good_r   <= 1'b0;
    end else begin
      if (cmd.accept) begin
        idx_r  <= idx_nxt;
        vcnt_r <= vcnt_nxt;
        sum_r  <= sum_nxt;
        err_r  <= err_nxt;
        wend_r <= wend_acc;
        good_r <= good_acc;
      end
      if (cmd.commit) begin
        heater_r <= heater_nxt;
        avg_r    <= avg_nxt;
        last_r   <= last_nxt;
      end
    end
  end

  // result register
  logic           out_valid_r, out_valid_nxt;
  aht_pkg::out_t  out_r;

  assign status.out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r.heater_on      <= heater_nxt;
      out_r.heater_changed <= heater_nxt != heater_r;
      out_r.window_end     <= wend_r;
      out_r.avg_valid      <= good_r;
      out_r.avg_temp       <= avg_nxt;
      out_r.report_temp    <= report;
      out_r.error_total    <= err_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("commit without result");

  a_avg_window: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.avg_valid) |-> out_r.window_end)
    else $error("average flagged outside window end");

  a_report_good: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.report_temp) |-> out_r.avg_valid)
    else $error("report without good window");

  a_heat_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && cfg_mode_r == aht_pkg::MODE_HEAT) |=> out_r.heater_on)
    else $error("heat mode not forcing heater on");

endmodule

`default_nettype wire
